[hw/rtl/bums_pkg.sv]
// ----------------------------------------------------------------------------
// Bottom-up merge sorter package
// Shared key width and sequencer state codes for the merge sorter.
// ----------------------------------------------------------------------------
package bums_pkg;

	// Width of one sorted key.
	localparam int DATA_W = 32;

	// Sequencer state codes.
	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_PRIME = 2'd1;
	localparam logic [1:0] ST_MERGE = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	// Sequencer state vector.
	typedef logic [1:0] seq_state_t;

endpackage

[hw/rtl/bottom_up_merge_sorter_unit.sv]
// ----------------------------------------------------------------------------
// Bottom-up merge sorter
// Collects a set of unsigned words, sorts it ascending by bottom-up merging
// between two ping-pong memories and streams the sorted words out.
// ----------------------------------------------------------------------------
// Words are loaded at one per cycle until the word flagged with tlast closes
// the set (at most MAX_ITEMS words; words arriving while the store is full are
// dropped, but a dropped tlast still closes the set). The set of n words is
// then sorted in ceil(log2(n)) merge passes; each pass opens with a priming
// step and then writes its n words, one word per cycle, limited by the single
// write port of the destination memory. Emission follows a further priming step
// at one word per cycle while the output side accepts. No new word is accepted
// from the closing word until the last sorted word has been handed to the
// output register. Each memory has one write and two registered read ports.
// ----------------------------------------------------------------------------
module bottom_up_merge_sorter_unit #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input stream: tdata = value[31:0]; tlast = last.
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [bums_pkg::DATA_W-1:0] s_axis_tdata,
	input  logic                        s_axis_tlast,
	// Output stream: tdata = sorted_value[31:0]; tlast = final_res.
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [bums_pkg::DATA_W-1:0] m_axis_tdata,
	output logic                        m_axis_tlast
);

	import bums_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int XW = CW + 1;

	// Ping-pong memories.
	logic [DATA_W-1:0] mem0 [MAX_ITEMS];
	logic [DATA_W-1:0] mem1 [MAX_ITEMS];
	logic [DATA_W-1:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;

	// Sequencer registers.
	seq_state_t    st_q, st_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          sel_q, sel_d;
	logic [XW-1:0] w_q, w_d;
	logic [XW-1:0] a_q, a_d, b_q, b_d, wp_q, wp_d;
	logic [XW-1:0] lend_q, lend_d, rend_q, rend_d;

	// Output register.
	logic              mv_q;
	logic [DATA_W-1:0] mdata_q;
	logic              mlast_q;

	// Combinational helpers.
	logic              s_fire, out_ld, take_a, a_ok, b_ok;
	logic              wr_en, wr_sel;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data, rd_a, rd_b;
	logic [XW-1:0]     n_x, w2, seg_l, seg_r;

	assign s_axis_tready = (st_q == ST_LOAD);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = mv_q;
	assign m_axis_tdata  = mdata_q;
	assign m_axis_tlast  = mlast_q;

	assign n_x  = XW'(cnt_q);
	assign w2   = w_q << 1;
	assign rd_a = sel_q ? rd1a_q : rd0a_q;
	assign rd_b = sel_q ? rd1b_q : rd0b_q;
	assign a_ok = (a_q < lend_q);
	assign b_ok = (b_q < rend_q);
	// On equal keys the right run is taken.
	assign take_a = a_ok && (!b_ok || (rd_a < rd_b));

	// Bounds of the next segment, starting where the current one ends.
	always_comb begin
		seg_l = rend_q + w_q;
		seg_r = rend_q + w2;
		if (seg_l > n_x) begin
			seg_l = n_x;
		end
		if (seg_r > n_x) begin
			seg_r = n_x;
		end
	end

	// Next-state logic of the sequencer.
	always_comb begin
		st_d    = st_q;
		cnt_d   = cnt_q;
		sel_d   = sel_q;
		w_d     = w_q;
		a_d     = a_q;
		b_d     = b_q;
		wp_d    = wp_q;
		lend_d  = lend_q;
		rend_d  = rend_q;
		wr_en   = 1'b0;
		wr_sel  = sel_q;
		wr_addr = cnt_q[AW-1:0];
		wr_data = s_axis_tdata;
		out_ld  = 1'b0;
		case (st_q)
			ST_LOAD: begin
				if (s_fire) begin
					if (cnt_q != CW'(MAX_ITEMS)) begin
						wr_en = 1'b1;
						cnt_d = cnt_q + CW'(1);
					end
					if (s_axis_tlast) begin
						st_d = ST_PRIME;
						w_d  = XW'(1);
					end
				end
			end
			ST_PRIME: begin
				// Issue the reads of the first heads of the pass.
				a_d  = '0;
				wp_d = '0;
				if (w_q >= n_x) begin
					st_d = ST_EMIT;
				end else begin
					st_d   = ST_MERGE;
					lend_d = w_q;
					rend_d = (w2 > n_x) ? n_x : w2;
					b_d    = w_q;
				end
			end
			ST_MERGE: begin
				wr_en   = 1'b1;
				wr_sel  = ~sel_q;
				wr_addr = wp_q[AW-1:0];
				wr_data = take_a ? rd_a : rd_b;
				if (wp_q + XW'(1) == rend_q) begin
					if (rend_q == n_x) begin
						// Pass complete: swap source and destination.
						w_d   = w2;
						sel_d = ~sel_q;
						st_d  = ST_PRIME;
					end else begin
						a_d    = rend_q;
						b_d    = seg_l;
						wp_d   = rend_q;
						lend_d = seg_l;
						rend_d = seg_r;
					end
				end else begin
					a_d  = a_q + XW'(take_a);
					b_d  = b_q + XW'(!take_a);
					wp_d = wp_q + XW'(1);
				end
			end
			ST_EMIT: begin
				if (!mv_q || m_axis_tready) begin
					out_ld = 1'b1;
					a_d    = a_q + XW'(1);
					if (a_q == n_x - XW'(1)) begin
						st_d  = ST_LOAD;
						cnt_d = '0;
					end
				end
			end
			default: begin
				st_d = ST_LOAD;
			end
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_LOAD;
			cnt_q <= '0;
			sel_q <= 1'b0;
			w_q   <= '0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			sel_q <= sel_d;
			w_q   <= w_d;
		end
	end

	// Pointers and segment bounds.
	always_ff @(posedge clk) begin
		a_q    <= a_d;
		b_q    <= b_d;
		wp_q   <= wp_d;
		lend_q <= lend_d;
		rend_q <= rend_d;
	end

	// Memories: reads follow the next pointer values, so the read data
	// always holds the heads at the current pointers.
	always_ff @(posedge clk) begin
		if (wr_en && !wr_sel) begin
			mem0[wr_addr] <= wr_data;
		end
		rd0a_q <= mem0[a_d[AW-1:0]];
		rd0b_q <= mem0[b_d[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_sel) begin
			mem1[wr_addr] <= wr_data;
		end
		rd1a_q <= mem1[a_d[AW-1:0]];
		rd1b_q <= mem1[b_d[AW-1:0]];
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (out_ld) begin
			mv_q <= 1'b1;
		end else if (m_axis_tready) begin
			mv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			mdata_q <= rd_a;
			mlast_q <= (a_q == n_x - XW'(1));
		end
	end

	// The write pointer is always the number of words taken so far in the pass.
	a_wp_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MERGE) |-> ((XW+1)'(wp_q) + (XW+1)'(lend_q) ==
			(XW+1)'(a_q) + (XW+1)'(b_q)))
		else $error("merge write pointer out of step with run pointers");

	// Run pointers never pass the ends of their runs.
	a_ptr_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MERGE) |-> (a_q <= lend_q && b_q <= rend_q && rend_q <= n_x))
		else $error("merge pointer beyond its run");

	// The set never exceeds the store.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ITEMS))
		else $error("item count beyond store depth");

	// Emission only starts once a single run covers the whole set.
	a_emit_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT) |-> (w_q >= n_x && cnt_q != '0))
		else $error("emission before sort complete");

endmodule

[dv/bottom_up_merge_sorter_unit_tb.sv]
// ----------------------------------------------------------------------------
// Bottom-up merge sorter testbench
// Streams sets of words into the sorter, closing each set with tlast. A
// behavioural sorter in the bench predicts each set's sorted output, and every
// word that leaves the block is checked against it. The run starts with a
// short table of hand-picked sets and continues with random sets. Both stream
// sides stall at random, and one long output stall fills the block up.
// ----------------------------------------------------------------------------
module bottom_up_merge_sorter_unit_tb;
	import bums_pkg::*;

	localparam int SET_MAX      = 64;
	localparam int HOLD_CYCLES  = 1000;
	localparam int DRAIN_CYCLES = 50;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int ROW_COUNT    = 22;

	// One row of the hand-written stimulus. When pinned is set, the row closes a
	// set of one word and its expected output is the typed value.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              last;
		logic              pinned;
		logic [DATA_W-1:0] pinned_value;
	} stim_row_t;

	// One expected word on the output side.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              is_last;
	} sorted_word_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata  = '0;
	logic              s_axis_tlast  = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;
	logic              m_axis_tlast;

	// Behavioural copy of the sorter state.
	logic [DATA_W-1:0] set_words [SET_MAX];
	logic [DATA_W-1:0] merge_buf [SET_MAX];
	logic [6:0]        set_count = '0;
	sorted_word_t      sorted_due [$];

	int failures      = 0;
	int cycle_count   = 0;
	int items_sent    = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	// Hand-picked sets: single words at both extremes, a reversed pair, equal
	// keys, partial last runs of three and five words, and mixed bit patterns.
	stim_row_t directed_rows [ROW_COUNT] = '{
		'{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
		'{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0000, 1'b1, 1'b0, 32'h0},
		'{32'h0000_0007, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0007, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0007, 1'b1, 1'b0, 32'h0},
		'{32'h0000_0001, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0002, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0003, 1'b1, 1'b0, 32'h0},
		'{32'h0000_0009, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0008, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0007, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0006, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0005, 1'b1, 1'b0, 32'h0},
		'{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
		'{32'h5555_5555, 1'b0, 1'b0, 32'h0},
		'{32'h8000_0000, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0001, 1'b0, 1'b0, 32'h0},
		'{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0000, 1'b1, 1'b0, 32'h0},
		'{32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678}
	};

	bottom_up_merge_sorter_unit #(
		.MAX_ITEMS(SET_MAX)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	// Clock with a period of ten time units.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Merge two neighbouring runs of the set through the buffer; on equal keys
	// the right run goes first.
	function automatic void merge_runs(int lo, int mid, int hi);
		int a;
		int b;
		int w;
		a = lo;
		b = mid + 1;
		w = lo;
		while (a <= mid && b <= hi) begin
			if (set_words[a] < set_words[b]) begin
				merge_buf[w] = set_words[a];
				a++;
			end else begin
				merge_buf[w] = set_words[b];
				b++;
			end
			w++;
		end
		while (a <= mid) begin
			merge_buf[w] = set_words[a];
			a++;
			w++;
		end
		while (b <= hi) begin
			merge_buf[w] = set_words[b];
			b++;
			w++;
		end
		for (int t = lo; t <= hi; t++) begin
			set_words[t] = merge_buf[t];
		end
	endfunction

	// Bottom-up passes of doubling run width. A last run without a right part
	// stays where it is.
	function automatic void sort_set(int n);
		int hi;
		for (int width = 1; width < n; width *= 2) begin
			for (int lo = 0; lo < n; lo += 2 * width) begin
				if (lo + width < n) begin
					hi = lo + 2 * width - 1;
					if (hi >= n) begin
						hi = n - 1;
					end
					merge_runs(lo, lo + width - 1, hi);
				end
			end
		end
	endfunction

	// Update the predicted state for one accepted word. A closing word sorts
	// the set and queues its words for the output side.
	function automatic void take_word(logic [DATA_W-1:0] value, logic last,
		logic pinned, logic [DATA_W-1:0] pinned_value);
		sorted_word_t due;
		if (set_count < SET_MAX) begin
			set_words[set_count] = value;
			set_count++;
		end
		if (last) begin
			sort_set(set_count);
			if (pinned) begin
				due.value   = pinned_value;
				due.is_last = 1'b1;
				sorted_due.push_back(due);
			end else begin
				for (int k = 0; k < set_count; k++) begin
					due.value   = set_words[k];
					due.is_last = (k + 1 == set_count);
					sorted_due.push_back(due);
				end
			end
			set_count = '0;
		end
	endfunction

	// Offer one word from a falling edge, with random gaps ahead of it, and
	// return at the falling edge after it has been taken.
	task automatic send_word(input logic [DATA_W-1:0] value, input logic last,
		input logic pinned, input logic [DATA_W-1:0] pinned_value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = value;
		s_axis_tlast  = last;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		take_word(value, last, pinned, pinned_value);
		items_sent++;
		@(negedge clk);
	endtask

	// Send one set of random words. Sets beyond the store size drop their tail,
	// closing word included.
	task automatic send_set(input int size);
		logic [DATA_W-1:0] value;
		for (int i = 0; i < size; i++) begin
			case ($urandom_range(3))
				0: value = $urandom_range(15);
				1: begin
					case ($urandom_range(3))
						0: value = 32'h0000_0000;
						1: value = 32'hFFFF_FFFF;
						2: value = 32'h8000_0000;
						default: value = 32'h7FFF_FFFF;
					endcase
				end
				default: value = $urandom;
			endcase
			send_word(value, i == size - 1, 1'b0, '0);
		end
	endtask

	// Random sets, mostly small, until the running word total reaches the goal.
	task automatic send_random_sets(input int item_goal);
		int pick;
		while (items_sent < item_goal) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				send_set($urandom_range(1, 8));
			end else if (pick < 85) begin
				send_set($urandom_range(9, 32));
			end else if (pick < 95) begin
				send_set($urandom_range(33, 63));
			end else begin
				send_set($urandom_range(64, 70));
			end
		end
	endtask

	// Keep the input side quiet until every predicted word has come out.
	task automatic await_sorted_drain();
		s_axis_tvalid = 1'b0;
		while (sorted_due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Output-side readiness: random stalls, or a long hold-off on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready = 1'b0;
			hold_left--;
		end else if (hold_seen != hold_requests) begin
			hold_seen     = hold_requests;
			hold_left     = HOLD_CYCLES - 1;
			m_axis_tready = 1'b0;
		end else begin
			m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check each word taken from the output against the oldest prediction.
	always @(posedge clk) begin
		sorted_word_t due;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (sorted_due.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual %h last %b",
					$time, m_axis_tdata, m_axis_tlast);
				failures++;
			end else begin
				due = sorted_due.pop_front();
				if (m_axis_tdata !== due.value) begin
					$display("%0t: sorted value mismatch: expected %h, actual %h",
						$time, due.value, m_axis_tdata);
					failures++;
				end
				if (m_axis_tlast !== due.is_last) begin
					$display("%0t: last flag mismatch: expected %b, actual %b",
						$time, due.is_last, m_axis_tlast);
					failures++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words still expected", $time, sorted_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Reset, then the directed table and three phases of random sets.
	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Sender idles lightly, receiver heavily.
		send_idle_pct = 25;
		recv_idle_pct = 77;
		for (int r = 0; r < ROW_COUNT; r++) begin
			send_word(directed_rows[r].value, directed_rows[r].last,
				directed_rows[r].pinned, directed_rows[r].pinned_value);
		end
		send_random_sets(110);
		await_sorted_drain();

		// Sender idles heavily, receiver lightly; starts with a full store.
		send_idle_pct = 77;
		recv_idle_pct = 25;
		send_set(SET_MAX);
		send_random_sets(220);
		await_sorted_drain();

		// No idling. The output is held off while an overfull set and the
		// following sets are offered, so the input side stalls.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests++;
		send_set(SET_MAX + 3);
		send_random_sets(320);
		await_sorted_drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/bums_pkg.sv
hw/rtl/bottom_up_merge_sorter_unit.sv
dv/bottom_up_merge_sorter_unit_tb.sv
